[design/gcd_pkg.sv]
package gcd_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int LAT_W = 24;
	localparam int LON_W = 25;
	localparam int DIST_W = 15;
	localparam int CFG_W = 25;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_REF_LAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_LON = 2'd1;

	// degrees -> binary angle: q = m*QUO + floor(m*REM/360)
	localparam longint PHASE_SCALE = longint'(1) << (32 - COORD_FRAC_BITS);
	localparam longint PHASE_QUO = PHASE_SCALE / 360;
	localparam longint PHASE_REM = PHASE_SCALE % 360;
	localparam int RECIP_SHIFT = 36;
	localparam longint PHASE_RECIP = ((longint'(1) << RECIP_SHIFT) + 359) / 360;
	localparam int MAG_W = LON_W;
	localparam int QUO_W = $clog2(PHASE_QUO + 1);
	localparam int REM_W = $clog2(PHASE_REM + 1);
	localparam int RECIP_W = $clog2(PHASE_RECIP + 1);
	localparam int PART_W = MAG_W + QUO_W;
	localparam int FRAC_W = MAG_W + REM_W;

	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS = 32;
	localparam int CR_W = 34;
	localparam int ANG_W = 34;
	localparam int COS_W = 32;
	localparam int Q30_W = 31;
	localparam int ROOT_W = 31;

	localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
	localparam logic [30:0] RADIUS_PI_Q16 = 31'd1311708728;
	localparam int DIST_SHIFT = 46;
	localparam logic [DIST_W-1:0] DIST_MAX = 15'd20015;

	localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335086,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
		30'd20, 30'd10, 30'd5, 30'd3, 30'd1
	};

endpackage

[design/gcd_cos_pipe.sv]
module gcd_cos_pipe (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [31:0] phase,
	output logic out_valid,
	output logic signed [gcd_pkg::COS_W-1:0] cosine
);
	localparam int N = gcd_pkg::CORDIC_STEPS;
	localparam int W = gcd_pkg::CR_W;
	localparam int AW = gcd_pkg::ANG_W;

	logic v_s [N+1];
	logic flip_s [N+1];
	logic signed [W-1:0] x_s [N+1];
	logic signed [W-1:0] y_s [N+1];
	logic signed [AW-1:0] z_s [N+1];
	logic fold;
	logic [31:0] folded;
	logic signed [W-1:0] x_end;

	// quadrants 1 and 2 rotate by half a turn, sign restored at the end
	assign fold = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
	assign folded = {phase[31] ^ fold, phase[30:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= W'(gcd_pkg::CORDIC_GAIN_Q30);
		y_s[0] <= '0;
		z_s[0] <= AW'($signed(folded));
		flip_s[0] <= fold;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [AW-1:0] ANG = AW'(gcd_pkg::ATAN_TURNS[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ANG;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ANG;
			end
		end
	end

	assign x_end = flip_s[N] ? -x_s[N] : x_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		cosine <= gcd_pkg::COS_W'(x_end);
	end

endmodule

[design/gcd_sqrt_pipe.sv]
module gcd_sqrt_pipe (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [gcd_pkg::Q30_W-1:0] radicand,
	output logic out_valid,
	output logic [gcd_pkg::ROOT_W-1:0] root
);
	localparam int N = gcd_pkg::SQRT_STEPS;
	localparam int NW = gcd_pkg::Q30_W + 30;
	localparam int TW = 2 * N - 1;

	logic v_s [N+1];
	logic [NW-1:0] n_s [N+1];
	logic [NW-1:0] res_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		n_s[0] <= {radicand, 30'd0};
		res_s[0] <= '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [TW-1:0] BIT = TW'(1) << (TW - 1 - 2 * k);
		logic [TW-1:0] trial;
		logic [TW-1:0] next_res;

		assign trial = TW'(res_s[k]) + BIT;
		assign next_res = (TW'(res_s[k]) >> 1) + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (TW'(n_s[k]) >= trial) begin
				n_s[k+1] <= n_s[k] - NW'(trial);
				res_s[k+1] <= NW'(next_res);
			end else begin
				n_s[k+1] <= n_s[k];
				res_s[k+1] <= res_s[k] >> 1;
			end
		end
	end

	assign out_valid = v_s[N];
	assign root = res_s[N][gcd_pkg::ROOT_W-1:0];

endmodule

[design/gcd_atan_pipe.sv]
module gcd_atan_pipe (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [gcd_pkg::ROOT_W-1:0] y_in,
	input  logic [gcd_pkg::ROOT_W-1:0] x_in,
	output logic out_valid,
	output logic signed [gcd_pkg::ANG_W-1:0] angle
);
	localparam int N = gcd_pkg::CORDIC_STEPS;
	localparam int W = gcd_pkg::CR_W;
	localparam int AW = gcd_pkg::ANG_W;

	logic v_s [N+1];
	logic signed [W-1:0] x_s [N+1];
	logic signed [W-1:0] y_s [N+1];
	logic signed [AW-1:0] z_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= W'(x_in);
		y_s[0] <= W'(y_in);
		z_s[0] <= '0;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [AW-1:0] ANG = AW'(gcd_pkg::ATAN_TURNS[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ANG;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ANG;
			end
		end
	end

	assign out_valid = v_s[N];
	assign angle = z_s[N];

endmodule

[design/great_circle_distance.sv]
// Haversine great-circle distance, in whole km (truncated, capped at 20015), from each
// latitude/longitude pair (Q8.16 latitude, Q9.16 longitude degrees) to the reference point held in the two
// configuration registers. A new item may be started every cycle; busy never rises.
// Each result appears on distance_km with done high for one cycle, in start order. There
// is no way to hold a result back, so the receiver must take it in that cycle. The
// result passes through a chain of pipelined units: degree conversion, cosine CORDIC,
// haversine products, square root, arctangent CORDIC and scaling. Write the reference
// only while no item is in flight.
module great_circle_distance (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [gcd_pkg::LAT_W-1:0] point_latitude,
	input  logic signed [gcd_pkg::LON_W-1:0] point_longitude,
	output logic done,
	output logic [gcd_pkg::DIST_W-1:0] distance_km,
	input  logic cfg_write,
	input  logic [gcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcd_pkg::CFG_W-1:0] cfg_data
);
	localparam int MW = gcd_pkg::MAG_W;
	localparam int PW = gcd_pkg::PART_W;
	localparam int FW = gcd_pkg::FRAC_W;
	localparam int RW = gcd_pkg::RECIP_W;
	localparam int QW = gcd_pkg::Q30_W;
	localparam int CW = gcd_pkg::COS_W;
	localparam int AW = gcd_pkg::ANG_W;
	localparam logic [gcd_pkg::QUO_W-1:0] QUO = gcd_pkg::QUO_W'(gcd_pkg::PHASE_QUO);
	localparam logic [FW-1:0] REM = FW'(gcd_pkg::PHASE_REM);
	localparam logic [RW-1:0] RECIP = RW'(gcd_pkg::PHASE_RECIP);

	// lanes: 0 point lat, 1 point lon, 2 ref lat, 3 ref lon
	logic signed [gcd_pkg::LAT_W-1:0] ref_lat_q;
	logic signed [gcd_pkg::LON_W-1:0] ref_lon_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [MW-1:0] coord_s1 [4];
	logic neg_s2 [4];
	logic [PW-1:0] part_s2 [4];
	logic [FW-1:0] frac_s2 [4];
	logic neg_s3 [4];
	logic [PW-1:0] part_s3 [4];
	logic [PW-1:0] quot_s3 [4];
	logic [31:0] phase_s4 [4];

	logic cos_valid;
	logic signed [CW-1:0] cos_dlat, cos_dlon, cos_rlat, cos_lat;

	logic valid_s5, valid_s6, valid_s7;
	logic signed [CW-1:0] hav_lat_s5, hav_lon_s5, hav_lat_s6;
	logic signed [2*CW-1:0] ccp_s5, cp_s6;
	logic signed [CW-1:0] cc;
	logic signed [CW+1:0] a_sum;
	logic [QW-1:0] a_s7;

	logic sqrt_valid;
	logic [gcd_pkg::ROOT_W-1:0] root_s, root_c;
	logic atan_valid;
	logic signed [AW-1:0] angle;

	logic valid_s8;
	logic [QW-1:0] z_clamp;
	logic [2*QW-1:0] prod_s8;
	logic [15:0] dist_raw;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				gcd_pkg::REG_REF_LAT: ref_lat_q <= cfg_data[gcd_pkg::LAT_W-1:0];
				gcd_pkg::REG_REF_LON: ref_lon_q <= cfg_data[gcd_pkg::LON_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= cos_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= atan_valid;
			done <= valid_s8;
		end
	end

	// degrees to binary angle, truncated toward zero
	always_ff @(posedge clk) begin
		coord_s1[0] <= MW'(point_latitude);
		coord_s1[1] <= point_longitude;
		coord_s1[2] <= MW'(ref_lat_q);
		coord_s1[3] <= ref_lon_q;
		for (int k = 0; k < 4; k++) begin
			logic [MW-1:0] mag;
			mag = coord_s1[k][MW-1] ? MW'(-coord_s1[k]) : MW'(coord_s1[k]);
			neg_s2[k] <= coord_s1[k][MW-1];
			part_s2[k] <= PW'(mag) * PW'(QUO);
			frac_s2[k] <= FW'(mag) * REM;
			neg_s3[k] <= neg_s2[k];
			part_s3[k] <= part_s2[k];
			quot_s3[k] <= PW'(((FW + RW)'(frac_s2[k]) * (FW + RW)'(RECIP))
				>> gcd_pkg::RECIP_SHIFT);
			phase_s4[k] <= neg_s3[k] ? 32'(-(part_s3[k] + quot_s3[k]))
				: 32'(part_s3[k] + quot_s3[k]);
		end
	end

	gcd_cos_pipe u_cos_dlat (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s4),
		.phase(phase_s4[0] - phase_s4[2]),
		.out_valid(cos_valid), .cosine(cos_dlat)
	);

	gcd_cos_pipe u_cos_dlon (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s4),
		.phase(phase_s4[1] - phase_s4[3]),
		.out_valid(), .cosine(cos_dlon)
	);

	gcd_cos_pipe u_cos_rlat (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s4),
		.phase(phase_s4[2]),
		.out_valid(), .cosine(cos_rlat)
	);

	gcd_cos_pipe u_cos_lat (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s4),
		.phase(phase_s4[0]),
		.out_valid(), .cosine(cos_lat)
	);

	// a = hav(dlat) + cos lat1 * cos lat2 * hav(dlon), clamped to 0..1
	assign cc = CW'(ccp_s5 >>> 30);
	assign a_sum = (CW + 2)'(hav_lat_s6) + (CW + 2)'(cp_s6 >>> 30);

	always_ff @(posedge clk) begin
		hav_lat_s5 <= CW'(((CW + 1)'($signed({1'b0, gcd_pkg::ONE_Q30}))
			- (CW + 1)'(cos_dlat)) >>> 1);
		hav_lon_s5 <= CW'(((CW + 1)'($signed({1'b0, gcd_pkg::ONE_Q30}))
			- (CW + 1)'(cos_dlon)) >>> 1);
		ccp_s5 <= (2 * CW)'(cos_rlat) * (2 * CW)'(cos_lat);
		hav_lat_s6 <= hav_lat_s5;
		cp_s6 <= (2 * CW)'(cc) * (2 * CW)'(hav_lon_s5);
		if (a_sum < 0) begin
			a_s7 <= '0;
		end else if (a_sum > (CW + 2)'($signed({1'b0, gcd_pkg::ONE_Q30}))) begin
			a_s7 <= gcd_pkg::ONE_Q30;
		end else begin
			a_s7 <= QW'(a_sum);
		end
	end

	gcd_sqrt_pipe u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s7),
		.radicand(a_s7),
		.out_valid(sqrt_valid), .root(root_s)
	);

	gcd_sqrt_pipe u_sqrt_c (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s7),
		.radicand(gcd_pkg::ONE_Q30 - a_s7),
		.out_valid(), .root(root_c)
	);

	gcd_atan_pipe u_atan (
		.clk(clk), .arst_n(arst_n), .in_valid(sqrt_valid),
		.y_in(root_s), .x_in(root_c),
		.out_valid(atan_valid), .angle(angle)
	);

	always_comb begin
		if (angle < 0) begin
			z_clamp = '0;
		end else if (angle > AW'($signed({1'b0, gcd_pkg::ONE_Q30}))) begin
			z_clamp = gcd_pkg::ONE_Q30;
		end else begin
			z_clamp = QW'(angle);
		end
	end

	assign dist_raw = prod_s8[gcd_pkg::DIST_SHIFT +: 16];

	always_ff @(posedge clk) begin
		prod_s8 <= (2 * QW)'(z_clamp) * (2 * QW)'(gcd_pkg::RADIUS_PI_Q16);
		distance_km <= (dist_raw > 16'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
			: gcd_pkg::DIST_W'(dist_raw);
	end

endmodule
